@@ sv/gsem_pkg.sv @@
`default_nettype none

package gsem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;
    localparam int WID_W      = COL_W + 1;
    localparam int ROOT_STEPS = 8;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
    localparam logic [12:0]      WC_RESET     = 13'd520;
    localparam logic [12:0]      WE_RESET     = 13'd488;
    localparam logic [12:0]      WK_RESET     = 13'd458;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH   = 3'd0,
        CFG_HEIGHT  = 3'd1,
        CFG_CENTER  = 3'd2,
        CFG_EDGE    = 3'd3,
        CFG_CORNER  = 3'd4,
        CFG_QUARTER = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE, S_RSH, S_SUM, S_M1, S_M2, S_M3, S_BSH,
        S_SOB, S_SQX, S_SQY, S_ROOT, S_OUT
    } t_state;

    // [row][col]: row 0 is the oldest line, col 2 the newest column
    typedef logic [2:0][2:0][7:0] t_win;

    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] res;
        logic [15:0] bits;
    } t_root;

endpackage

`default_nettype wire

@@ sv/gsem_ram.sv @@
`default_nettype none

module gsem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/gsem_window.sv @@
`default_nettype none

module gsem_window (
    input  wire logic                      i_clk,
    input  wire logic [gsem_pkg::COL_W-1:0] i_col,
    input  wire logic                      i_shift,
    input  wire logic [7:0]                i_pix,
    output gsem_pkg::t_win                 o_win
);

    import gsem_pkg::*;

    logic [7:0] w_up1;
    logic [7:0] w_up2;
    t_win       r_win;

    // line one above the newest, then two above
    gsem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line1 (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (i_col),
        .i_wdata (i_pix),
        .i_raddr (i_col),
        .o_rdata (w_up1)
    );

    gsem_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line2 (
        .i_clk   (i_clk),
        .i_we    (i_shift),
        .i_waddr (i_col),
        .i_wdata (w_up1),
        .i_raddr (i_col),
        .o_rdata (w_up2)
    );

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= w_up2;
            r_win[1][2] <= w_up1;
            r_win[2][2] <= i_pix;
        end
    end

    assign o_win = r_win;

endmodule

`default_nettype wire

@@ sv/gsem_root_cell.sv @@
`default_nettype none

module gsem_root_cell (
    input  wire logic          i_clk,
    input  wire gsem_pkg::t_root i_in,
    output gsem_pkg::t_root    o_out
);

    import gsem_pkg::*;

    logic [16:0] w_trial;
    t_root       r_out;

    assign w_trial = {1'b0, i_in.res} + {1'b0, i_in.bits};

    // one result bit per cell
    always_ff @(posedge i_clk) begin
        if ({1'b0, i_in.rem} >= w_trial) begin
            r_out.rem <= i_in.rem - w_trial[15:0];
            r_out.res <= (i_in.res >> 1) + i_in.bits;
        end else begin
            r_out.rem <= i_in.rem;
            r_out.res <= i_in.res >> 1;
        end
        r_out.bits <= i_in.bits >> 2;
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

@@ sv/gaussian_sobel_edge_magnitude.sv @@
// Channel  | valid    | stall     | payload
// request  | i_valid  | o_stall   | i_opcode, i_pixel
// result   | o_valid  | i_stall   | o_magnitude, o_gradient_x, o_gradient_y, o_last_of_frame
//
// One request at a time. A flush while pixels are still due is taken and ignored; a pixel
// passes S_RSH alone before the blur lag is filled, and S_RSH to S_BSH when it only
// advances the blur. A request that yields a result also uses one shared 13x10 multiplier
// (three blur taps, two squares) and an eight-cell square-root chain.
// Reset (synchronous, i_rst_n low) restores the register defaults and frame counters.
// A finished result waits in the output register while i_stall is high; the next
// request is still taken meanwhile.
`default_nettype none

module gaussian_sobel_edge_magnitude (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_opcode,
    input  wire logic [7:0]                      i_pixel,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_magnitude,
    output logic signed [10:0]                   o_gradient_x,
    output logic signed [10:0]                   o_gradient_y,
    output logic                                 o_last_of_frame,
    input  wire logic                            i_cfg_we,
    input  wire logic [gsem_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gsem_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import gsem_pkg::*;

    t_state r_state, n_state;

    logic [WID_W-1:0] r_fw;
    logic [ROW_W-1:0] r_fh;
    logic [12:0]      r_wc, r_we, r_wk;
    logic             r_quarter;

    logic [WID_W-1:0] w_wid, w_wm1;
    logic [ROW_W-1:0] w_ht, w_hm1;

    logic [COL_W-1:0] r_cin, r_cq, r_co;
    logic [ROW_W-1:0] r_rin, r_rq;
    logic [ROW_W-2:0] r_ro;

    logic [7:0]  r_pix, r_pe;
    logic [9:0]  r_se, r_sk;
    logic        r_bord;
    logic [24:0] r_acc;
    logic signed [10:0] r_gx, r_gy;
    logic        r_last;
    logic [ROOT_CNT_W-1:0] r_rcnt;

    logic        r_ovld;
    logic [7:0]  r_omag;
    logic signed [10:0] r_ogx, r_ogy;
    logic        r_olast;

    logic        w_accept, w_raw_done, w_qv, w_ov, w_out_last, w_geo_wr;
    logic        c_raw_shift, c_blur_shift, c_out_load;
    t_win        w_rwin, w_bwin;
    logic [7:0]  w_bval;
    logic [12:0] w_ma;
    logic [9:0]  w_mb;
    logic [22:0] w_prod;
    logic [9:0]  w_agx, w_agy;
    logic signed [11:0] w_gx, w_gy, w_gxq, w_gyq;
    logic        w_interior;
    t_root       w_chain [ROOT_STEPS+1];

    // effective geometry
    always_comb begin
        w_wid = r_fw;
        if (r_fw < WID_W'(3)) w_wid = WID_W'(3);
        if (r_fw > WID_W'(MAX_WIDTH)) w_wid = WID_W'(MAX_WIDTH);
        w_ht = r_fh;
        if (r_fh < ROW_W'(3)) w_ht = ROW_W'(3);
        if (r_fh > ROW_W'(MAX_HEIGHT)) w_ht = ROW_W'(MAX_HEIGHT);
    end
    assign w_wm1 = w_wid - WID_W'(1);
    assign w_hm1 = w_ht - ROW_W'(1);

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_raw_done = (r_rin >= w_ht);
    assign w_geo_wr   = i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT);

    // blur centre lags the raw pixel by one line and one pixel, output by two of each
    assign w_qv = (r_rin > ROW_W'(1)) || (r_rin == ROW_W'(1) && r_cin != '0);
    assign w_ov = (r_rq > ROW_W'(1)) || (r_rq == ROW_W'(1) && r_cq != '0);
    assign w_out_last = ({1'b0, r_ro} == w_hm1) && ({1'b0, r_co} == w_wm1);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw      <= WIDTH_RESET;
            r_fh      <= HEIGHT_RESET;
            r_wc      <= WC_RESET;
            r_we      <= WE_RESET;
            r_wk      <= WK_RESET;
            r_quarter <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:   r_fw      <= i_cfg_data[WID_W-1:0];
                CFG_HEIGHT:  r_fh      <= i_cfg_data[ROW_W-1:0];
                CFG_CENTER:  r_wc      <= i_cfg_data[12:0];
                CFG_EDGE:    r_we      <= i_cfg_data[12:0];
                CFG_CORNER:  r_wk      <= i_cfg_data[12:0];
                CFG_QUARTER: r_quarter <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_raw_done || i_opcode == OP_PIXEL)) n_state = S_RSH;
            end
            S_RSH:  n_state = w_qv ? S_SUM : S_IDLE;
            S_SUM:  n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_BSH;
            S_BSH:  n_state = w_ov ? S_SOB : S_IDLE;
            S_SOB:  n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_ROOT;
            S_ROOT: n_state = (r_rcnt == ROOT_CNT_W'(ROOT_STEPS - 1)) ? S_OUT : S_ROOT;
            S_OUT:  n_state = c_out_load ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        c_raw_shift  = (r_state == S_RSH);
        c_blur_shift = (r_state == S_BSH);
        c_out_load   = (r_state == S_OUT) && (!r_ovld || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_geo_wr || (r_state == S_SOB && w_out_last)) begin
            r_cin <= '0;
            r_rin <= '0;
            r_cq  <= '0;
            r_rq  <= '0;
            r_co  <= '0;
            r_ro  <= '0;
        end else begin
            if (c_raw_shift) begin
                if ({1'b0, r_cin} == w_wm1) begin
                    r_cin <= '0;
                    r_rin <= r_rin + ROW_W'(1);
                end else begin
                    r_cin <= r_cin + COL_W'(1);
                end
            end
            if (c_blur_shift) begin
                if ({1'b0, r_cq} == w_wm1) begin
                    r_cq <= '0;
                    r_rq <= r_rq + ROW_W'(1);
                end else begin
                    r_cq <= r_cq + COL_W'(1);
                end
            end
            if (r_state == S_SOB) begin
                if ({1'b0, r_co} == w_wm1) begin
                    r_co <= '0;
                    r_ro <= r_ro + (ROW_W-1)'(1);
                end else begin
                    r_co <= r_co + COL_W'(1);
                end
            end
        end
    end

    gsem_window u_raw (
        .i_clk   (i_clk),
        .i_col   (r_cin),
        .i_shift (c_raw_shift),
        .i_pix   (r_pix),
        .o_win   (w_rwin)
    );

    gsem_window u_blur (
        .i_clk   (i_clk),
        .i_col   (r_cq),
        .i_shift (c_blur_shift),
        .i_pix   (w_bval),
        .o_win   (w_bwin)
    );

    // shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_M1:  begin w_ma = r_wc; w_mb = {2'b0, r_pe}; end
            S_M2:  begin w_ma = r_we; w_mb = r_se; end
            S_M3:  begin w_ma = r_wk; w_mb = r_sk; end
            S_SQX: begin w_ma = {3'b0, w_agx}; w_mb = w_agx; end
            S_SQY: begin w_ma = {3'b0, w_agy}; w_mb = w_agy; end
            default: ;
        endcase
    end
    assign w_prod = w_ma * w_mb;

    assign w_agx = r_gx[10] ? 10'(-r_gx) : r_gx[9:0];
    assign w_agy = r_gy[10] ? 10'(-r_gy) : r_gy[9:0];

    // border pixels of the blurred image are the raw centre
    assign w_bval = r_bord ? r_pe : ((|r_acc[24:20]) ? 8'hFF : r_acc[19:12]);

    always_comb begin
        w_gx = ({4'b0, w_bwin[0][2]} + {3'b0, w_bwin[1][2], 1'b0} + {4'b0, w_bwin[2][2]})
             - ({4'b0, w_bwin[0][0]} + {3'b0, w_bwin[1][0], 1'b0} + {4'b0, w_bwin[2][0]});
        w_gy = ({4'b0, w_bwin[2][0]} + {3'b0, w_bwin[2][1], 1'b0} + {4'b0, w_bwin[2][2]})
             - ({4'b0, w_bwin[0][0]} + {3'b0, w_bwin[0][1], 1'b0} + {4'b0, w_bwin[0][2]});
        // round toward zero before the arithmetic shift
        w_gxq = (w_gx + (w_gx[11] ? 12'sd3 : 12'sd0)) >>> 2;
        w_gyq = (w_gy + (w_gy[11] ? 12'sd3 : 12'sd0)) >>> 2;
    end
    assign w_interior = (r_ro != '0) && ({1'b0, r_ro} != w_hm1)
                     && (r_co != '0) && ({1'b0, r_co} != w_wm1);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_pix <= w_raw_done ? 8'd0 : i_pixel;
            end
            S_SUM: begin
                r_pe   <= w_rwin[1][1];
                r_se   <= {2'b0, w_rwin[0][1]} + {2'b0, w_rwin[2][1]}
                        + {2'b0, w_rwin[1][0]} + {2'b0, w_rwin[1][2]};
                r_sk   <= {2'b0, w_rwin[0][0]} + {2'b0, w_rwin[0][2]}
                        + {2'b0, w_rwin[2][0]} + {2'b0, w_rwin[2][2]};
                r_bord <= (r_rq == '0) || (r_rq == w_hm1)
                       || (r_cq == '0) || ({1'b0, r_cq} == w_wm1);
            end
            S_M1:  r_acc <= {2'b0, w_prod};
            S_M2:  r_acc <= r_acc + {2'b0, w_prod};
            S_M3:  r_acc <= r_acc + {2'b0, w_prod};
            S_SOB: begin
                if (!w_interior) begin
                    r_gx <= '0;
                    r_gy <= '0;
                end else if (r_quarter) begin
                    r_gx <= w_gxq[10:0];
                    r_gy <= w_gyq[10:0];
                end else begin
                    r_gx <= w_gx[10:0];
                    r_gy <= w_gy[10:0];
                end
                r_last <= w_out_last;
            end
            S_SQX: r_acc <= {2'b0, w_prod};
            S_SQY: r_acc <= r_acc + {2'b0, w_prod};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROOT) r_rcnt <= r_rcnt + ROOT_CNT_W'(1);
        else                   r_rcnt <= '0;
    end

    assign w_chain[0] = '{rem: r_acc[15:0], res: 16'd0, bits: 16'h4000};

    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
        gsem_root_cell u_cell (
            .i_clk (i_clk),
            .i_in  (w_chain[k]),
            .o_out (w_chain[k+1])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (c_out_load) begin
            r_ovld <= 1'b1;
        end else if (!i_stall) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_omag  <= (|r_acc[20:16]) ? 8'hFF : w_chain[ROOT_STEPS].res[7:0];
            r_ogx   <= r_gx;
            r_ogy   <= r_gy;
            r_olast <= r_last;
        end
    end

    assign o_valid         = r_ovld;
    assign o_magnitude     = r_omag;
    assign o_gradient_x    = r_ogx;
    assign o_gradient_y    = r_ogy;
    assign o_last_of_frame = r_olast;

endmodule

`default_nettype wire

@@ sv/gsem_checker.sv @@
`default_nettype none

module gsem_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [7:0]                      o_magnitude,
    input wire logic signed [10:0]              o_gradient_x,
    input wire logic signed [10:0]              o_gradient_y,
    input wire logic                            o_last_of_frame
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_magnitude) && $stable(o_gradient_x)
                               && $stable(o_gradient_y) && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // no gradient means no magnitude
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gradient_x == 11'sd0 && o_gradient_y == 11'sd0 |-> o_magnitude == 8'd0)
        else $error("magnitude without gradient");

    // last pixel of a frame sits on the border
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame |-> o_magnitude == 8'd0 && o_gradient_x == 11'sd0
                                        && o_gradient_y == 11'sd0)
        else $error("border result not zero");

endmodule

bind gaussian_sobel_edge_magnitude gsem_checker u_gsem_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import gsem_pkg::*;

    localparam int RING     = 16384;
    localparam int WD_LIMIT = 6000;
    localparam int HOLD_AT  = 3000;
    localparam int HOLD_LEN = 600;

    typedef struct {
        logic       op;
        logic [7:0] pix;
    } t_request;

    typedef struct {
        logic [7:0]         mag;
        logic signed [10:0] gx;
        logic signed [10:0] gy;
        logic               last;
    } t_edge;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_opcode = OP_PIXEL;
    logic [7:0]         i_pixel = 8'd0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [7:0]         o_magnitude;
    logic signed [10:0] o_gradient_x;
    logic signed [10:0] o_gradient_y;
    logic               o_last_of_frame;
    logic               i_cfg_we = 1'b0;
    t_cfg_idx           i_cfg_index = CFG_WIDTH;
    logic [12:0]        i_cfg_data = 13'd0;

    gaussian_sobel_edge_magnitude dut (.*);

    always #4 i_clk = ~i_clk;

    // mirror of the block's state
    int unsigned pix_store [RING];
    int unsigned m_width = 640, m_height = 480;
    int unsigned m_wc = 520, m_we = 488, m_wk = 458, m_quarter = 0;
    int unsigned in_count = 0, out_pos = 0;

    t_request pending_requests[$];
    t_edge    edges_due[$];
    bit       calm = 1'b0;
    int       fails = 0, n_in = 0, n_out = 0, n_frames = 0, n_cycle = 0, hold_left = 0;

    function automatic int unsigned eff_w();
        return m_width < 3 ? 3 : (m_width > MAX_WIDTH ? MAX_WIDTH : m_width);
    endfunction

    function automatic int unsigned eff_h();
        return m_height < 3 ? 3 : (m_height > MAX_HEIGHT ? MAX_HEIGHT : m_height);
    endfunction

    function automatic int unsigned raw(int unsigned p);
        return pix_store[p % RING];
    endfunction

    function automatic int unsigned blurred(int unsigned r, int unsigned c,
                                            int unsigned w, int unsigned h);
        int unsigned p, acc;
        p = r * w + c;
        if (r == 0 || r == h - 1 || c == 0 || c == w - 1)
            return raw(p);
        acc = m_wc * raw(p)
            + m_we * (raw(p - w) + raw(p + w) + raw(p - 1) + raw(p + 1))
            + m_wk * (raw(p - w - 1) + raw(p - w + 1) + raw(p + w - 1) + raw(p + w + 1));
        acc = acc >> 12;
        return acc > 255 ? 255 : acc;
    endfunction

    function automatic void emit_edge(int unsigned w, int unsigned h);
        int unsigned r, c, s, root, t;
        int b [3][3];
        int gx, gy;
        t_edge e;
        r = out_pos / w;
        c = out_pos % w;
        gx = 0;
        gy = 0;
        root = 0;
        if (r != 0 && r != h - 1 && c != 0 && c != w - 1) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    b[i][j] = blurred(r + i - 1, c + j - 1, w, h);
            gx = (b[0][2] + 2 * b[1][2] + b[2][2]) - (b[0][0] + 2 * b[1][0] + b[2][0]);
            gy = (b[2][0] + 2 * b[2][1] + b[2][2]) - (b[0][0] + 2 * b[0][1] + b[0][2]);
            if (m_quarter != 0) begin
                gx = gx / 4;
                gy = gy / 4;
            end
            s = gx * gx + gy * gy;
            if (s >= 65536) root = 255;
            else
                for (int k = 7; k >= 0; k--) begin
                    t = root | (1 << k);
                    if (t * t <= s) root = t;
                end
        end
        e.mag  = root[7:0];
        e.gx   = gx[10:0];
        e.gy   = gy[10:0];
        e.last = (out_pos == w * h - 1);
        edges_due.push_back(e);
        out_pos++;
        if (out_pos >= w * h) begin
            in_count = 0;
            out_pos = 0;
            n_frames++;
        end
    endfunction

    function automatic void predict_edges(logic op, logic [7:0] pix);
        int unsigned w, h;
        w = eff_w();
        h = eff_h();
        if (in_count < w * h) begin
            if (op == OP_FLUSH) return;
            pix_store[in_count % RING] = pix;
            in_count++;
            if (in_count >= out_pos + 2 * (w + 1) + 1) emit_edge(w, h);
        end else
            emit_edge(w, h);
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_edges(i_opcode, i_pixel);
                void'(pending_requests.pop_front());
                n_in++;
            end
            if (!(i_valid && o_stall)) begin
                if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 22)) begin
                    i_valid  <= 1'b1;
                    i_opcode <= pending_requests[0].op;
                    i_pixel  <= pending_requests[0].pix;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor; one long hold-off to back the block up
    always @(posedge i_clk) begin
        t_edge e;
        if (i_rst_n) begin
            n_cycle++;
            if (n_cycle == HOLD_AT) hold_left = HOLD_LEN;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 22);
            end
            if (o_valid && !i_stall) begin
                n_out++;
                if (edges_due.size() == 0) begin
                    $error("unexpected result: mag %0d gx %0d gy %0d",
                           o_magnitude, o_gradient_x, o_gradient_y);
                    fails++;
                end else begin
                    e = edges_due.pop_front();
                    if (o_magnitude !== e.mag) begin
                        $error("magnitude: expected %0d, got %0d", e.mag, o_magnitude);
                        fails++;
                    end
                    if (o_gradient_x !== e.gx) begin
                        $error("gradient_x: expected %0d, got %0d", e.gx, o_gradient_x);
                        fails++;
                    end
                    if (o_gradient_y !== e.gy) begin
                        $error("gradient_y: expected %0d, got %0d", e.gy, o_gradient_y);
                        fails++;
                    end
                    if (o_last_of_frame !== e.last) begin
                        $error("last_of_frame: expected %0d, got %0d", e.last,
                               o_last_of_frame);
                        fails++;
                    end
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        int idle;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle = 0;
        else idle++;
        if (idle >= WD_LIMIT) begin
            $display("timeout: %0d requests pending, %0d results due",
                     pending_requests.size(), edges_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [12:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_WIDTH:   begin m_width = data[10:0]; in_count = 0; out_pos = 0; end
            CFG_HEIGHT:  begin m_height = data; in_count = 0; out_pos = 0; end
            CFG_CENTER:  m_wc = data;
            CFG_EDGE:    m_we = data;
            CFG_CORNER:  m_wk = data;
            CFG_QUARTER: m_quarter = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [12:0] w, logic [12:0] h, logic [12:0] wc,
                         logic [12:0] we, logic [12:0] wk, logic q);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        write_reg(CFG_CENTER, wc);
        write_reg(CFG_EDGE, we);
        write_reg(CFG_CORNER, wk);
        write_reg(CFG_QUARTER, {12'd0, q});
    endtask

    task automatic push(logic op, logic [7:0] pix);
        t_request r;
        r.op = op;
        r.pix = pix;
        pending_requests.push_back(r);
    endtask

    // wait until everything is taken and answered, then let flushes settle
    task automatic settle();
        wait (pending_requests.size() == 0 && edges_due.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, int unsigned noise);
        for (int unsigned k = 0; k < w * h; k++) begin
            if ($urandom_range(0, 99) < noise) push(OP_FLUSH, 8'($urandom));
            push(OP_PIXEL, 8'($urandom));
        end
        // drain: pixels here are discarded and act as flushes
        for (int unsigned k = 0; k < 2 * (w + 1); k++)
            push(($urandom_range(0, 99) < noise) ? OP_PIXEL : OP_FLUSH, 8'($urandom));
    endtask

    initial begin
        int unsigned w, h, sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x3 frame from undersized geometry, blur saturating, quarter scale;
        // a flush mid-frame is ignored, pixels during the drain act as flushes
        setup(13'd0, 13'd1, 13'd4096, 13'd4096, 13'd4096, 1'b1);
        push(OP_PIXEL, 8'd0);   push(OP_PIXEL, 8'd255); push(OP_FLUSH, 8'd77);
        push(OP_PIXEL, 8'd0);   push(OP_PIXEL, 8'd255); push(OP_PIXEL, 8'd0);
        push(OP_PIXEL, 8'd255); push(OP_PIXEL, 8'd0);   push(OP_PIXEL, 8'd255);
        push(OP_PIXEL, 8'd255);
        for (int k = 0; k < 8; k++) push(k[0] ? OP_PIXEL : OP_FLUSH, 8'd255);
        settle();

        // zero weights: interior blurs to zero, full scale, full-swing pixels
        setup(13'd4, 13'd4, 13'd0, 13'd0, 13'd0, 1'b0);
        for (int k = 0; k < 16; k++) push(OP_PIXEL, (k % 3 == 0) ? 8'd255 : 8'd0);
        for (int k = 0; k < 10; k++) push(OP_FLUSH, 8'd0);
        settle();

        // oversized width saturates to the widest line; partly sent, the next
        // geometry write restarts it
        setup(13'h1FFF, 13'd3, 13'd520, 13'd488, 13'd458, 1'b0);
        for (int k = 0; k < 48; k++) push(OP_PIXEL, 8'($urandom));
        settle();

        // wider line, one frame of three rows
        setup(13'd100, 13'd3, 13'd520, 13'd488, 13'd458, 1'b0);
        send_frame(100, 3, 0);
        settle();

        // tallest frame, partly sent; the next geometry write restarts it
        setup(13'd3, 13'h1FFF, 13'd1, 13'd4095, 13'd0, 1'b1);
        for (int k = 0; k < 120; k++) push(OP_PIXEL, 8'($urandom));
        settle();

        sent = 0;
        for (int ph = 0; sent < 600; ph++) begin
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            calm = (ph == 3);
            case ($urandom_range(0, 5))
                0: setup(13'(w), 13'(h), 13'd4096, 13'($urandom_range(0, 4096)), 13'd0,
                         1'($urandom));
                1: setup(13'(w), 13'(h), 13'd0, 13'd0, 13'($urandom_range(0, 4096)),
                         1'($urandom));
                default: setup(13'(w), 13'(h), 13'($urandom_range(0, 4096)),
                               13'($urandom_range(0, 4096)),
                               13'($urandom_range(0, 4096)), 1'($urandom));
            endcase
            if ($urandom_range(0, 99) < 85) begin
                send_frame(w, h, $urandom_range(0, 8));
                if ($urandom_range(0, 3) == 0) send_frame(w, h, 0);
            end else begin
                // broken frame: cut short, noisy
                for (int k = $urandom_range(1, w * h + 2 * w); k > 0; k--)
                    push($urandom_range(0, 99) < 30, 8'($urandom));
            end
            sent += pending_requests.size();
            settle();
            calm = 1'b0;
        end

        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d complete frames", n_in, n_out,
                 n_frames);
        $display("geometry from 3x3 up to 100 wide, with saturated width and height");
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
